// File: hw/rtl/ldsf_pkg.sv
// ----------------------------------------------------------------------------
// ldsf_pkg
// Shared types and constants for the LED driver serial framer.
// ----------------------------------------------------------------------------
package ldsf_pkg;

   localparam int ADDR_REG_W   = 7;   // width of the start address register
   localparam int ADDR_FIELD_W = 8;   // address carried to the serialiser
   localparam int ID_BITS      = 3;   // frame ID length
   localparam int BYTE_BITS    = 8;
   localparam int CMD_BITS     = 12;  // ID, command byte, trailing zero

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   // Classified item passed from the front end to the serialiser
   typedef struct packed {
      logic                    is_data;
      logic                    opens;    // send write ID and address first
      logic                    closes;   // raise chip select after this byte
      logic [BYTE_BITS-1:0]    payload;
      logic [ADDR_FIELD_W-1:0] address;
   } desc_type;

endpackage

// File: hw/rtl/ldsf_if.sv
// ----------------------------------------------------------------------------
// ldsf_if
// Valid/ready channel interfaces for the request, response and CSR ports.
// ----------------------------------------------------------------------------
interface ldsf_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] payload;

   modport source (output valid, output opcode, output payload, input ready);
   modport sink   (input valid, input opcode, input payload, output ready);
endinterface

interface ldsf_rsp_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic frame_start;
   logic frame_end;
   logic last;

   modport source (output valid, output data_bit, output frame_start,
                   output frame_end, output last, input ready);
   modport sink   (input valid, input data_bit, input frame_start,
                   input frame_end, input last, output ready);
endinterface

interface ldsf_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] start_address;

   modport source (output valid, output start_address, input ready);
   modport sink   (input valid, input start_address, output ready);
endinterface

// File: hw/rtl/ldsf_front.sv
// ----------------------------------------------------------------------------
// ldsf_front
// Accepts request transactions, tracks frame state and classifies each item.
// ----------------------------------------------------------------------------
module ldsf_front #(
   parameter int FRAME_BYTES = 24
) (
   input  logic               clock,
   input  logic               reset,
   ldsf_req_if.sink           req_if,
   ldsf_csr_if.sink           csr_if,
   output logic               desc_valid,
   input  logic               desc_ready,
   output ldsf_pkg::desc_type desc
);

   localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   logic [CNT_W-1:0]                bytes_sent_ff, bytes_sent_in;
   logic                            frame_open_ff, frame_open_in;
   logic [ldsf_pkg::ADDR_REG_W-1:0] start_address_ff, start_address_in;
   logic [CNT_W-1:0]                cur_count;
   logic                            is_data;
   logic                            closing;
   logic                            accept;

   assign req_if.ready = desc_ready;
   assign desc_valid   = req_if.valid;
   assign accept       = req_if.valid && desc_ready;
   assign csr_if.ready = 1'b1;

   assign is_data   = (req_if.opcode == ldsf_pkg::OP_DATA);
   assign cur_count = frame_open_ff ? bytes_sent_ff : '0;
   assign closing   = (cur_count == CNT_W'(FRAME_BYTES - 1));

   always_comb begin
      desc.is_data = is_data;
      desc.opens   = is_data && !frame_open_ff;
      desc.closes  = is_data && closing;
      desc.payload = req_if.payload;
      desc.address = {{(ldsf_pkg::ADDR_FIELD_W - ldsf_pkg::ADDR_REG_W){1'b0}},
                      start_address_ff};
   end

   always_comb begin
      bytes_sent_in    = bytes_sent_ff;
      frame_open_in    = frame_open_ff;
      start_address_in = start_address_ff;
      if (csr_if.valid) begin
         start_address_in = csr_if.start_address;
      end
      if (accept) begin
         // a command drops any open frame
         if (!is_data || closing) begin
            bytes_sent_in = '0;
            frame_open_in = 1'b0;
         end else begin
            bytes_sent_in = cur_count + CNT_W'(1);
            frame_open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_sent_ff    <= '0;
         frame_open_ff    <= 1'b0;
         start_address_ff <= '0;
      end else begin
         bytes_sent_ff    <= bytes_sent_in;
         frame_open_ff    <= frame_open_in;
         start_address_ff <= start_address_in;
      end
   end

endmodule

// File: hw/rtl/ldsf_queue.sv
// ----------------------------------------------------------------------------
// ldsf_queue
// Short first-in first-out queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
module ldsf_queue #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/ldsf_serialiser.sv
// ----------------------------------------------------------------------------
// ldsf_serialiser
// Expands each classified item into its bit sequence, one bit per cycle while rsp_if is ready.
// ----------------------------------------------------------------------------
module ldsf_serialiser #(
   parameter int ADDRESS_BITS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_valid,
   output logic               desc_ready,
   input  ldsf_pkg::desc_type desc,
   ldsf_rsp_if.source         rsp_if
);

   localparam int SEQ_W = ldsf_pkg::ID_BITS + ADDRESS_BITS + ldsf_pkg::BYTE_BITS + 1;
   localparam int CNT_W = $clog2(SEQ_W + 1);

   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             first_ff, first_in;
   logic             end_ff, end_in;
   logic             out_valid_ff;
   logic             out_bit_ff, out_fs_ff, out_fe_ff, out_last_ff;

   logic [SEQ_W-1:0] load_seq;
   logic [CNT_W-1:0] load_cnt;
   logic             load_fs, load_fe;
   logic             advance, emit, final_bit, done, pop;

   assign advance   = !out_valid_ff || rsp_if.ready;
   assign emit      = advance && (remain_ff != '0);
   assign final_bit = (remain_ff == CNT_W'(1));
   assign done      = (remain_ff == '0) || (final_bit && advance);
   assign pop       = done && desc_valid;
   assign desc_ready = done;

   always_comb begin
      load_seq = '0;
      if (!desc.is_data) begin
         load_seq[0] = 1'b1;
         for (int k = 0; k < ldsf_pkg::BYTE_BITS; k++) begin
            load_seq[ldsf_pkg::ID_BITS + k] = desc.payload[ldsf_pkg::BYTE_BITS - 1 - k];
         end
         load_cnt = CNT_W'(ldsf_pkg::CMD_BITS);
         load_fs  = 1'b1;
         load_fe  = 1'b1;
      end else if (desc.opens) begin
         load_seq[0] = 1'b1;
         load_seq[2] = 1'b1;
         for (int k = 0; k < ADDRESS_BITS; k++) begin
            load_seq[ldsf_pkg::ID_BITS + k] = desc.address[ADDRESS_BITS - 1 - k];
         end
         for (int k = 0; k < ldsf_pkg::BYTE_BITS; k++) begin
            load_seq[ldsf_pkg::ID_BITS + ADDRESS_BITS + k] = desc.payload[k];
         end
         load_cnt = CNT_W'(SEQ_W - 1);
         load_fs  = 1'b1;
         load_fe  = desc.closes;
      end else begin
         for (int k = 0; k < ldsf_pkg::BYTE_BITS; k++) begin
            load_seq[k] = desc.payload[k];
         end
         load_cnt = CNT_W'(ldsf_pkg::BYTE_BITS);
         load_fs  = 1'b0;
         load_fe  = desc.closes;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      remain_in = remain_ff;
      first_in  = first_ff;
      end_in    = end_ff;
      if (pop) begin
         seq_in    = load_seq;
         remain_in = load_cnt;
         first_in  = load_fs;
         end_in    = load_fe;
      end else if (emit) begin
         seq_in    = seq_ff >> 1;
         remain_in = remain_ff - CNT_W'(1);
         first_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         if (advance) begin
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      first_ff <= first_in;
      end_ff   <= end_in;
      if (emit) begin
         out_bit_ff  <= seq_ff[0];
         out_fs_ff   <= first_ff;
         out_fe_ff   <= end_ff && final_bit;
         out_last_ff <= final_bit;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.data_bit    = out_bit_ff;
   assign rsp_if.frame_start = out_fs_ff;
   assign rsp_if.frame_end   = out_fe_ff;
   assign rsp_if.last        = out_last_ff;

endmodule

// File: hw/rtl/led_driver_serial_framer.sv
// ----------------------------------------------------------------------------
// led_driver_serial_framer
// Serial framer for a three-wire LED matrix driver.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per transaction: opcode 0 sends a command byte
//   as a complete frame, opcode 1 sends a display data byte.
//   rsp_if gives one transaction per serial bit, with frame_start on the
//   first bit after chip select falls, frame_end on the bit after which it
//   rises and last on the final bit of each item.
//   csr_if writes the start address, sent after the write ID when a data
//   frame opens; write it only while the block is idle.
// Throughput: one bit per cycle from the serialiser's shift register while
//   rsp_if is ready, so a data byte in an open frame is 8 bits, a
//   frame-opening byte 11 + ADDRESS_BITS bits and a command 12 bits.
// Path: an accepted item is written to the queue, loaded into the
//   serialiser's shift register and shown from its output register.
// A two-entry queue parts the front end from the serialiser, so requests
//   are taken while rsp_if stalls until it is full; a stalled bit holds.
// Reset clears the queue, the serialiser and the frame state and sets the
//   start address to zero.
// ----------------------------------------------------------------------------
module led_driver_serial_framer #(
   parameter int FRAME_BYTES  = 24,
   parameter int ADDRESS_BITS = 7
) (
   input  logic        clock,
   input  logic        reset,
   ldsf_req_if.sink    req_if,
   ldsf_rsp_if.source  rsp_if,
   ldsf_csr_if.sink    csr_if
);

   localparam int DESC_W = $bits(ldsf_pkg::desc_type);

   ldsf_pkg::desc_type front_desc;
   ldsf_pkg::desc_type back_desc;
   logic               front_valid, front_ready;
   logic               back_valid, back_ready;

   ldsf_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .desc_valid (front_valid),
      .desc_ready (front_ready),
      .desc       (front_desc)
   );

   ldsf_queue #(
      .WIDTH (DESC_W),
      .DEPTH (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_desc),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_data  (back_desc)
   );

   ldsf_serialiser #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_serialiser (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (back_valid),
      .desc_ready (back_ready),
      .desc       (back_desc),
      .rsp_if     (rsp_if)
   );

endmodule

// File: hw/rtl/ldsf_checker.sv
// ----------------------------------------------------------------------------
// ldsf_checker
// Port-level assertions for the LED driver serial framer.
// ----------------------------------------------------------------------------
module ldsf_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic data_bit,
   input logic frame_start,
   input logic frame_end,
   input logic last
);

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every frame opens with an ID starting in a one
   a_start_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_start |-> data_bit)
      else $error("frame start bit is not one");

   // chip select rises only at the end of an item
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> last)
      else $error("frame end away from last bit");

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_start |-> !last)
      else $error("frame start on last bit");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_bit)
         && $stable(frame_start) && $stable(frame_end) && $stable(last))
      else $error("stalled response changed");

endmodule

bind led_driver_serial_framer ldsf_checker u_ldsf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .data_bit    (rsp_if.data_bit),
   .frame_start (rsp_if.frame_start),
   .frame_end   (rsp_if.frame_end),
   .last        (rsp_if.last)
);

// File: tb/led_driver_serial_framer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_driver_serial_framer_test
// Self-checking bench for the LED driver serial framer. Command and data
// bytes are sent through the request channel, and each serial bit on the
// response channel is checked against a bit-level model of the framing. The
// start address is rewritten between phases. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module led_driver_serial_framer_test;

   localparam int FRAME_LEN = 24;
   localparam int ADDR_LEN  = 7;

   typedef struct {
      logic       opcode;
      logic [7:0] payload;
   } matrix_item_type;

   typedef struct packed {
      logic data_bit;
      logic frame_start;
      logic frame_end;
      logic last;
   } strobe_bit_type;

   logic clock;
   logic reset;

   ldsf_req_if req_if ();
   ldsf_rsp_if rsp_if ();
   ldsf_csr_if csr_if ();

   led_driver_serial_framer #(
      .FRAME_BYTES  (FRAME_LEN),
      .ADDRESS_BITS (ADDR_LEN)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   matrix_item_type pending_items[$];
   strobe_bit_type  expected_bits[$];

   // model of the framer state
   logic [6:0] cfg_address;
   logic       frame_open_model;
   int         bytes_in_frame;

   int              error_count;
   bit              idle_on;
   int              send_gap;
   int              stall_left;
   matrix_item_type next_item;
   strobe_bit_type  observed_bit;
   strobe_bit_type  wanted_bit;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_bit(input logic d, input logic fs, input logic fe);
      expected_bits.push_back('{d, fs, fe, 1'b0});
   endfunction

   // Expand one accepted item into the serial bits it puts on the data line
   function automatic void serialise_item(input logic op, input logic [7:0] pay);
      logic           closing;
      strobe_bit_type tail;
      if (op == ldsf_pkg::OP_COMMAND) begin
         // drop any open data frame
         frame_open_model = 1'b0;
         bytes_in_frame   = 0;
         push_bit(1'b1, 1'b1, 1'b0);
         push_bit(1'b0, 1'b0, 1'b0);
         push_bit(1'b0, 1'b0, 1'b0);
         for (int i = 7; i >= 0; i--) push_bit(pay[i], 1'b0, 1'b0);
         push_bit(1'b0, 1'b0, 1'b1);
      end else begin
         if (!frame_open_model) begin
            push_bit(1'b1, 1'b1, 1'b0);
            push_bit(1'b0, 1'b0, 1'b0);
            push_bit(1'b1, 1'b0, 1'b0);
            for (int i = ADDR_LEN - 1; i >= 0; i--) push_bit(cfg_address[i], 1'b0, 1'b0);
            frame_open_model = 1'b1;
            bytes_in_frame   = 0;
         end
         closing = (bytes_in_frame + 1) >= FRAME_LEN;
         for (int i = 0; i < 8; i++) push_bit(pay[i], 1'b0, closing && i == 7);
         if (closing) begin
            frame_open_model = 1'b0;
            bytes_in_frame   = 0;
         end else begin
            bytes_in_frame = (bytes_in_frame + 1) & 31;
         end
      end
      tail      = expected_bits.pop_back();
      tail.last = 1'b1;
      expected_bits.push_back(tail);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            serialise_item(req_if.opcode, req_if.payload);
            send_gap = pick_gap();
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the offered transaction
         end else if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_if.valid   <= 1'b1;
            req_if.opcode  <= next_item.opcode;
            req_if.payload <= next_item.payload;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            observed_bit = '{rsp_if.data_bit, rsp_if.frame_start, rsp_if.frame_end,
                             rsp_if.last};
            if (expected_bits.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected bit data=%b start=%b end=%b last=%b", $realtime,
                           observed_bit.data_bit, observed_bit.frame_start,
                           observed_bit.frame_end, observed_bit.last);
            end else begin
               wanted_bit = expected_bits.pop_front();
               if (observed_bit !== wanted_bit) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: mismatch data %b/%b start %b/%b end %b/%b last %b/%b",
                              $realtime, wanted_bit.data_bit, observed_bit.data_bit,
                              wanted_bit.frame_start, observed_bit.frame_start,
                              wanted_bit.frame_end, observed_bit.frame_end,
                              wanted_bit.last, observed_bit.last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   function automatic void add_item(input logic op, input logic [7:0] pay);
      matrix_item_type it;
      it.opcode  = op;
      it.payload = pay;
      pending_items.push_back(it);
   endfunction

   // Mostly runs of data bytes, long enough now and then to close a frame,
   // with commands and odd items mixed in
   function automatic void add_random_items(input int n);
      int count;
      int r;
      int len;
      count = 0;
      while (count < n) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
            repeat (len) add_item(ldsf_pkg::OP_DATA, 8'($urandom_range(0, 255)));
            count += len;
         end else if (r < 88) begin
            add_item(ldsf_pkg::OP_COMMAND, 8'($urandom_range(0, 255)));
            count++;
         end else begin
            add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            count++;
         end
      end
   endfunction

   // Call just after a rising edge, with the block idle
   task automatic write_start_address(input logic [6:0] value);
      csr_if.valid         <= 1'b1;
      csr_if.start_address <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cfg_address = value;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_if.valid || expected_bits.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = ldsf_pkg::OP_COMMAND;
      req_if.payload       = 8'h00;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.start_address = 7'h00;
      cfg_address          = 7'h00;
      frame_open_model     = 1'b0;
      bytes_in_frame       = 0;
      error_count          = 0;
      idle_on              = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset address, extreme bytes, command dropping an open frame
      add_item(ldsf_pkg::OP_COMMAND, 8'h00);
      add_item(ldsf_pkg::OP_COMMAND, 8'hFF);
      add_item(ldsf_pkg::OP_DATA, 8'h01);
      add_item(ldsf_pkg::OP_DATA, 8'h80);
      add_item(ldsf_pkg::OP_DATA, 8'hFF);
      add_item(ldsf_pkg::OP_COMMAND, 8'h5A);
      add_item(ldsf_pkg::OP_DATA, 8'h00);
      add_item(ldsf_pkg::OP_COMMAND, 8'hA5);
      wait_drained();

      idle_on = 1'b1;
      write_start_address(7'h7F);
      add_item(ldsf_pkg::OP_DATA, 8'h55);
      add_item(ldsf_pkg::OP_DATA, 8'hAA);
      add_item(ldsf_pkg::OP_COMMAND, 8'hFF);
      add_item(ldsf_pkg::OP_DATA, 8'hFF);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         idle_on = (phase != 2);
         case (phase)
            0:       write_start_address(7'h00);
            3:       write_start_address(7'h7F);
            default: write_start_address(7'($urandom_range(0, 127)));
         endcase
         add_random_items(30);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
